### rtl/lzss_stream_decoder_unit_assert.svh
// Assertion macros for the LZSS stream decoder RTL.
`ifndef LZSS_STREAM_DECODER_UNIT_ASSERT_SVH
`define LZSS_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LZSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzsd assertion failed");

// Next-cycle implication, checked outside reset.
`define LZSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzsd assertion failed");

`endif

### rtl/lzsd_pkg.sv
// Types and constants of the LZSS stream decoder.
package lzsd_pkg;

    typedef logic [7:0] t_byte;

    // Byte lanes of one result and the per-token result limit.
    localparam int unsigned LANES       = 4;
    localparam int unsigned MAX_RESULTS = 64;
    localparam int unsigned CNT_W       = 3;

endpackage

### rtl/lzsd_hist_mem.sv
// History store: one write port, one registered read port.
module lzsd_hist_mem #(
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned AW    = 16
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  lzsd_pkg::t_byte    i_wr_data,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output lzsd_pkg::t_byte    o_rd_data
);

    lzsd_pkg::t_byte r_mem [DEPTH];
    lzsd_pkg::t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/lzss_stream_decoder_unit.sv
// Top level of the LZSS stream decoder: token parser, copy sequencer, output register.
//
// Input channel (i_t*): one compressed payload byte per transaction in i_tdata;
// i_tuser marks the first byte of a stream and restarts flag parsing and the
// history fill count (the write position keeps running).
// Output channel (o_t*): up to four decoded bytes per transaction, lane 0 first,
// with the valid byte count; i_tuser-style flag o_tuser flags a bad match
// distance (count 0, no data); o_tlast marks the final result of an input byte.
// Flag and distance bytes are taken and give no result. A literal is written to
// history and its result is loaded in the flush state. Each byte of a match
// needs a history read in the read state (registered RAM port) and then a
// write back at the write position in the copy state.
// i_tready is high only while the sequencer is idle.
// When the receiver stalls, the finished result stays in the output register
// and the sequencer holds before completing the next result.
// Reset (synchronous, active low) empties the output register, returns the
// sequencer to idle and expects a flag byte; history contents are not cleared.
module lzss_stream_decoder_unit #(
    parameter int unsigned HISTORY_DEPTH    = 65536,
    parameter int unsigned BYTES_PER_RESULT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        i_tready,
    input  logic [7:0]  i_tdata,    // [7:0] data_byte
    input  logic        i_tuser,    // [0] stream_start
    output logic        o_tvalid,
    input  logic        o_tready,
    output logic [39:0] o_tdata,    // [7:0] out_byte0, [15:8] out_byte1, [23:16] out_byte2,
                                    // [31:24] out_byte3, [34:32] byte_count, [39:35] zero
    output logic        o_tuser,    // [0] bad_distance
    output logic        o_tlast     // last_of_run
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam int unsigned PW = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned DW = 17;
    localparam int unsigned WBASE = (BYTES_PER_RESULT < 1) ? 1 :
                                    ((BYTES_PER_RESULT > lzsd_pkg::LANES) ?
                                     lzsd_pkg::LANES : BYTES_PER_RESULT);
    localparam int unsigned LSH = $clog2(lzsd_pkg::MAX_RESULTS);
    localparam int unsigned FW  = $clog2(lzsd_pkg::LANES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_COPY  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    localparam logic [1:0] MP_NONE = 2'd0;
    localparam logic [1:0] MP_LOW  = 2'd1;
    localparam logic [1:0] MP_HIGH = 2'd2;

    localparam int unsigned CW = lzsd_pkg::CNT_W;

    // parser state
    logic [1:0]  r_state, n_state;
    logic        r_await, n_await;
    logic [7:0]  r_flags, n_flags;
    logic [2:0]  r_idx, n_idx;
    logic [1:0]  r_mph, n_mph;
    logic [15:0] r_dist, n_dist;
    logic [AW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_prod, n_prod;

    // copy sequencer and pending result
    logic [7:0]    r_rem, n_rem;
    logic [CW-1:0] r_wid, n_wid;
    logic [FW-1:0] r_fill, n_fill;
    lzsd_pkg::t_byte r_lane [lzsd_pkg::LANES];
    lzsd_pkg::t_byte n_lane [lzsd_pkg::LANES];
    logic [CW-1:0] r_pcnt, n_pcnt;
    logic          r_pbad, n_pbad;

    // output register
    logic            r_ov;
    lzsd_pkg::t_byte r_ob [lzsd_pkg::LANES];
    logic [CW-1:0]   r_ocnt;
    logic            r_obad;
    logic            r_olast;

    logic            s_load;
    lzsd_pkg::t_byte s_lb [lzsd_pkg::LANES];
    logic [CW-1:0]   s_lcnt;
    logic            s_lbad;
    logic            s_llast;

    // memory port
    logic            s_wr_en;
    logic [AW-1:0]   s_wr_addr;
    lzsd_pkg::t_byte s_wr_data;
    logic            s_rd_en;
    logic [AW-1:0]   s_rd_addr;
    lzsd_pkg::t_byte s_rd_data;

    logic            s_acc;
    logic            s_out_free;
    logic            s_start;
    logic            e_await;
    logic [7:0]      e_flags;
    logic [2:0]      e_idx;
    logic [1:0]      e_mph;
    logic [15:0]     e_dist;
    logic [PW-1:0]   e_prod;
    logic            s_bad;
    logic [CW-1:0]   s_need;
    logic [DW-1:0]   s_wp_x;
    logic [DW-1:0]   s_dist_x;
    logic [AW-1:0]   s_wp_inc;
    logic [PW-1:0]   s_prod_inc;
    logic            s_done;

    lzsd_hist_mem #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (s_wr_addr),
        .i_wr_data (s_wr_data),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    assign i_tready   = (r_state == S_IDLE);
    assign s_acc      = i_tvalid && i_tready;
    assign s_out_free = !r_ov || o_tready;
    assign s_start    = i_tuser;

    // stream start clears parse state before the byte is handled
    assign e_await = s_start | r_await;
    assign e_flags = s_start ? 8'd0 : r_flags;
    assign e_idx   = s_start ? 3'd0 : r_idx;
    assign e_mph   = s_start ? MP_NONE : r_mph;
    assign e_dist  = s_start ? 16'd0 : r_dist;
    assign e_prod  = s_start ? '0 : r_prod;

    assign s_bad  = (e_dist == 16'd0) || ({1'b0, e_dist} > DW'(e_prod));
    assign s_need = CW'((DW'(i_tdata) + DW'(lzsd_pkg::MAX_RESULTS - 1)) >> LSH);

    assign s_wp_inc   = (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign s_prod_inc = (r_prod < PW'(HISTORY_DEPTH)) ? r_prod + PW'(1) : r_prod;
    assign s_wp_x     = DW'(r_wp);
    assign s_dist_x   = {1'b0, r_dist};
    assign s_done     = (r_rem == 8'd1) || ({1'b0, r_fill} + CW'(1) == r_wid);

    always_comb begin
        n_state   = r_state;
        n_await   = r_await;
        n_flags   = r_flags;
        n_idx     = r_idx;
        n_mph     = r_mph;
        n_dist    = r_dist;
        n_wp      = r_wp;
        n_prod    = r_prod;
        n_rem     = r_rem;
        n_wid     = r_wid;
        n_fill    = r_fill;
        n_lane    = r_lane;
        n_pcnt    = r_pcnt;
        n_pbad    = r_pbad;
        s_wr_en   = 1'b0;
        s_wr_addr = r_wp;
        s_wr_data = i_tdata;
        s_rd_en   = 1'b0;
        s_rd_addr = '0;
        s_load    = 1'b0;
        s_lb      = r_lane;
        s_lcnt    = r_pcnt;
        s_lbad    = r_pbad;
        s_llast   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_await = e_await;
                    n_flags = e_flags;
                    n_idx   = e_idx;
                    n_mph   = e_mph;
                    n_dist  = e_dist;
                    n_prod  = e_prod;
                    if (e_await) begin
                        n_flags = i_tdata;
                        n_await = 1'b0;
                    end else if (e_mph == MP_LOW) begin
                        n_dist = {i_tdata, e_dist[7:0]};
                        n_mph  = MP_HIGH;
                    end else if (e_mph == MP_HIGH) begin
                        n_mph = MP_NONE;
                        n_idx = e_idx + 3'd1;
                        if (e_idx == 3'd7) begin
                            n_await = 1'b1;
                        end
                        for (int i = 0; i < lzsd_pkg::LANES; i++) begin
                            n_lane[i] = '0;
                        end
                        n_fill = '0;
                        if (s_bad) begin
                            n_pcnt  = '0;
                            n_pbad  = 1'b1;
                            n_state = S_FLUSH;
                        end else if (i_tdata != 8'd0) begin
                            n_rem   = i_tdata;
                            n_wid   = (s_need > CW'(WBASE)) ? s_need : CW'(WBASE);
                            n_state = S_READ;
                        end
                    end else if (e_flags[3'd7 - e_idx]) begin
                        n_dist = {8'd0, i_tdata};
                        n_mph  = MP_LOW;
                    end else begin
                        // literal: store and emit one byte
                        s_wr_en   = 1'b1;
                        s_wr_data = i_tdata;
                        n_wp      = s_wp_inc;
                        n_prod    = (e_prod < PW'(HISTORY_DEPTH)) ? e_prod + PW'(1) : e_prod;
                        n_lane[0] = i_tdata;
                        for (int i = 1; i < lzsd_pkg::LANES; i++) begin
                            n_lane[i] = '0;
                        end
                        n_pcnt  = CW'(1);
                        n_pbad  = 1'b0;
                        n_idx   = e_idx + 3'd1;
                        if (e_idx == 3'd7) begin
                            n_await = 1'b1;
                        end
                        n_state = S_FLUSH;
                    end
                end
            end
            S_READ: begin
                s_rd_en = 1'b1;
                if (s_wp_x >= s_dist_x) begin
                    s_rd_addr = AW'(s_wp_x - s_dist_x);
                end else begin
                    s_rd_addr = AW'(s_wp_x + DW'(HISTORY_DEPTH) - s_dist_x);
                end
                n_state = S_COPY;
            end
            S_COPY: begin
                s_lb         = r_lane;
                s_lb[r_fill] = s_rd_data;
                s_lcnt       = CW'(r_fill) + CW'(1);
                s_lbad       = 1'b0;
                s_llast      = (r_rem == 8'd1);
                // hold when the result would complete but the output is full
                if (!s_done || s_out_free) begin
                    s_wr_en   = 1'b1;
                    s_wr_data = s_rd_data;
                    n_wp      = s_wp_inc;
                    n_prod    = s_prod_inc;
                    n_rem     = r_rem - 8'd1;
                    if (s_done) begin
                        s_load = 1'b1;
                        n_fill = '0;
                        for (int i = 0; i < lzsd_pkg::LANES; i++) begin
                            n_lane[i] = '0;
                        end
                    end else begin
                        n_lane[r_fill] = s_rd_data;
                        n_fill         = r_fill + FW'(1);
                    end
                    n_state = (r_rem == 8'd1) ? S_IDLE : S_READ;
                end
            end
            S_FLUSH: begin
                if (s_out_free) begin
                    s_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_await <= 1'b1;
            r_flags <= '0;
            r_idx   <= '0;
            r_mph   <= MP_NONE;
            r_dist  <= '0;
            r_wp    <= '0;
            r_prod  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_await <= n_await;
            r_flags <= n_flags;
            r_idx   <= n_idx;
            r_mph   <= n_mph;
            r_dist  <= n_dist;
            r_wp    <= n_wp;
            r_prod  <= n_prod;
            if (s_load) begin
                r_ov <= 1'b1;
            end else if (o_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_wid  <= n_wid;
        r_fill <= n_fill;
        r_lane <= n_lane;
        r_pcnt <= n_pcnt;
        r_pbad <= n_pbad;
        if (s_load) begin
            r_ob    <= s_lb;
            r_ocnt  <= s_lcnt;
            r_obad  <= s_lbad;
            r_olast <= s_llast;
        end
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = {5'd0, r_ocnt, r_ob[3], r_ob[2], r_ob[1], r_ob[0]};
    assign o_tuser  = r_obad;
    assign o_tlast  = r_olast;

`include "lzss_stream_decoder_unit_assert.svh"

    `LZSD_ASSERT_NEXT(a_copy_holds, i_clk, i_rst_n, r_state == S_COPY && s_done && !s_out_free, r_state == S_COPY && $stable(r_wp))
    `LZSD_ASSERT_NOW(a_bad_empty, i_clk, i_rst_n, o_tvalid && o_tuser, o_tdata[34:32] == 3'd0 && o_tlast)
    `LZSD_ASSERT_NOW(a_good_count, i_clk, i_rst_n, o_tvalid && !o_tuser, o_tdata[34:32] != 3'd0 && o_tdata[34:32] <= 3'd4)
    `LZSD_ASSERT_NOW(a_match_no_flag, i_clk, i_rst_n, r_mph != MP_NONE, !r_await && r_state == S_IDLE)

endmodule
